// File: sv/jdr_pkg.sv
// ----------------------------------------------------------------------------
// jdr_pkg
// Types and constants shared by the join de-duplication and removal deadline
// table block.
// ----------------------------------------------------------------------------
package jdr_pkg;

	typedef enum logic [2:0] {
		OP_JOIN    = 3'd0,
		OP_SCHED   = 3'd1,
		OP_QUERY   = 3'd2,
		OP_COLLECT = 3'd3,
		OP_LEFT    = 3'd4
	} op_t;

	localparam logic [15:0] ADDR_NONE    = 16'hFFFF;
	localparam logic [15:0] ADDR_ZERO    = 16'h0000;
	localparam logic [31:0] WINDOW_RESET = 32'd5000;
	localparam int          MAX_RESULTS  = 8;
	localparam int          RPT_W        = $clog2(MAX_RESULTS + 1);

	typedef struct packed {
		logic start;
		logic step;
		logic finish;
	} jdr_cmd_t;

	typedef struct packed {
		logic done;
		logic step_ok;
		logic out_free;
	} jdr_status_t;

endpackage

// File: sv/jdr_if.sv
// ----------------------------------------------------------------------------
// jdr channel interfaces
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface jdr_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  op;
	logic [15:0] dev_addr;
	logic [31:0] now_ms;
	logic [31:0] due_ms;
	modport source (output valid, op, dev_addr, now_ms, due_ms, input ready);
	modport sink (input valid, op, dev_addr, now_ms, due_ms, output ready);
endinterface

interface jdr_rsp_if;
	logic        valid;
	logic        ready;
	logic        flag;
	logic [31:0] time_left_ms;
	logic [15:0] expired_addr;
	logic        last;
	modport source (output valid, flag, time_left_ms, expired_addr, last, input ready);
	modport sink (input valid, flag, time_left_ms, expired_addr, last, output ready);
endinterface

interface jdr_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// File: sv/jdr_ctrl.sv
// ----------------------------------------------------------------------------
// jdr_ctrl
// Controller: accepts a request word, steps the table scan and closes the
// operation once the response register is free.
// ----------------------------------------------------------------------------
module jdr_ctrl import jdr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  jdr_status_t st,
	output jdr_cmd_t    cmd
);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} state_t;

	state_t state_q;
	logic   ready_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: cmd.start = req_valid && ready_q;
			S_SCAN: cmd.step = !st.done && st.step_ok;
			S_FIN: cmd.finish = st.out_free;
			default: cmd = '0;
		endcase
	end

	assign req_ready = ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				S_IDLE: if (req_valid && ready_q) begin
					state_q <= S_SCAN;
					ready_q <= 1'b0;
				end
				S_SCAN: if (st.done) begin
					state_q <= S_FIN;
				end
				S_FIN: if (st.out_free) begin
					state_q <= S_IDLE;
					ready_q <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

// File: sv/jdr_dp.sv
// ----------------------------------------------------------------------------
// jdr_dp
// Datapath: join and removal tables, scan trackers that examine one entry per
// cycle unless a waiting response word holds the scan, and the response register.
// ----------------------------------------------------------------------------
module jdr_dp import jdr_pkg::*; #(
	parameter int JOIN_SLOTS   = 8,
	parameter int REMOVE_SLOTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  jdr_cmd_t    cmd,
	output jdr_status_t st,
	input  logic [2:0]  req_op,
	input  logic [15:0] req_addr,
	input  logic [31:0] req_now,
	input  logic [31:0] req_dl,
	input  logic        cfg_we,
	input  logic [31:0] cfg_data,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic        rsp_flag,
	output logic [31:0] rsp_rem,
	output logic [15:0] rsp_addr,
	output logic        rsp_last
);

	localparam int MAXS = (JOIN_SLOTS > REMOVE_SLOTS) ? JOIN_SLOTS : REMOVE_SLOTS;
	localparam int JW   = (JOIN_SLOTS > 1) ? $clog2(JOIN_SLOTS) : 1;
	localparam int RW   = (REMOVE_SLOTS > 1) ? $clog2(REMOVE_SLOTS) : 1;
	localparam int IW   = (MAXS > 1) ? $clog2(MAXS) : 1;
	localparam int CW   = $clog2(MAXS + 1);

	logic [JOIN_SLOTS-1:0]   jv_q;
	logic [15:0]             ja_q [JOIN_SLOTS];
	logic [31:0]             jt_q [JOIN_SLOTS];
	logic [REMOVE_SLOTS-1:0] rv_q;
	logic [15:0]             ra_q [REMOVE_SLOTS];
	logic [31:0]             rd_q [REMOVE_SLOTS];
	logic [31:0]             win_q;

	logic [2:0]       op_q;
	logic [15:0]      addr_q;
	logic [31:0]      now_q;
	logic [31:0]      dl_q;
	logic [CW-1:0]    idx_q;
	logic             hit_q;
	logic             bad_q;
	logic             flag_q;
	logic [31:0]      rem_q;
	logic             free_found_q;
	logic [IW-1:0]    free_idx_q;
	logic             old_found_q;
	logic [IW-1:0]    old_idx_q;
	logic [31:0]      old_time_q;
	logic [RPT_W-1:0] rpt_q;
	logic             pend_q;
	logic [15:0]      pend_addr_q;
	logic             ovalid_q;
	logic             oflag_q;
	logic [31:0]      orem_q;
	logic [15:0]      oaddr_q;
	logic             olast_q;

	logic [JW-1:0] jidx;
	logic [RW-1:0] ridx;
	logic          j_in, r_in, jhit, jfree, jdup, jvalid;
	logic          rvalid, rmatch, rfree, rreach, expired, emit_mid;
	logic [31:0]   jt, rd, rdiff, rrem;
	logic [CW-1:0] limit;
	logic          out_free, bad_in, join_new, sched_new;
	logic [JW-1:0] jtgt;
	logic [RW-1:0] rtgt;

	assign jidx   = idx_q[JW-1:0];
	assign ridx   = idx_q[RW-1:0];
	assign j_in   = idx_q < CW'(JOIN_SLOTS);
	assign r_in   = idx_q < CW'(REMOVE_SLOTS);
	assign jt     = jt_q[jidx];
	assign jvalid = j_in && jv_q[jidx];
	assign jhit   = jvalid && (ja_q[jidx] == addr_q);
	assign jfree  = j_in && !jv_q[jidx];
	assign jdup   = (now_q - jt) <= win_q;
	assign rd     = rd_q[ridx];
	assign rvalid = r_in && rv_q[ridx];
	assign rmatch = rvalid && (ra_q[ridx] == addr_q);
	assign rfree  = r_in && !rv_q[ridx];
	assign rdiff  = now_q - rd;
	assign rreach = !rdiff[31];
	assign rrem   = rreach ? 32'd0 : (rd - now_q);
	assign expired  = (op_q == OP_COLLECT) && rvalid && rreach;
	assign emit_mid = expired && pend_q && (rpt_q < RPT_W'(MAX_RESULTS));
	assign out_free = !ovalid_q || rsp_ready;
	assign bad_in   = (req_addr == ADDR_ZERO) || (req_addr == ADDR_NONE);
	assign join_new  = (op_q == OP_JOIN) && !bad_q && !hit_q;
	assign sched_new = (op_q == OP_SCHED) && !bad_q && !hit_q && free_found_q;
	assign jtgt = free_found_q ? free_idx_q[JW-1:0] : old_idx_q[JW-1:0];
	assign rtgt = free_idx_q[RW-1:0];

	always_comb begin
		case (op_q)
			OP_JOIN: limit = CW'(JOIN_SLOTS);
			OP_LEFT: limit = CW'(MAXS);
			default: limit = CW'(REMOVE_SLOTS);
		endcase
	end

	assign st.done     = hit_q || (idx_q >= limit);
	assign st.step_ok  = !emit_mid || out_free;
	assign st.out_free = out_free;

	assign rsp_valid = ovalid_q;
	assign rsp_flag  = oflag_q;
	assign rsp_rem   = orem_q;
	assign rsp_addr  = oaddr_q;
	assign rsp_last  = olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jv_q     <= '0;
			rv_q     <= '0;
			win_q    <= WINDOW_RESET;
			hit_q    <= 1'b0;
			idx_q    <= '0;
			ovalid_q <= 1'b0;
			pend_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				win_q <= cfg_data;
			end
			if ((cmd.step && emit_mid) || cmd.finish) begin
				ovalid_q <= 1'b1;
			end else if (rsp_ready) begin
				ovalid_q <= 1'b0;
			end
			if (cmd.start) begin
				idx_q        <= '0;
				hit_q        <= (req_op > OP_LEFT) || ((req_op != OP_COLLECT) && bad_in);
				bad_q        <= bad_in;
				flag_q       <= 1'b0;
				rem_q        <= '0;
				free_found_q <= 1'b0;
				old_found_q  <= 1'b0;
				rpt_q        <= '0;
				pend_q       <= 1'b0;
			end
			if (cmd.step) begin
				idx_q <= idx_q + 1'b1;
				case (op_q)
					OP_JOIN: begin
						if (jhit) begin
							hit_q  <= 1'b1;
							flag_q <= jdup;
						end else if (jfree) begin
							if (!free_found_q) begin
								free_found_q <= 1'b1;
								free_idx_q   <= idx_q[IW-1:0];
							end
						end else if (jvalid && (!old_found_q || jt < old_time_q)) begin
							old_found_q <= 1'b1;
							old_idx_q   <= idx_q[IW-1:0];
							old_time_q  <= jt;
						end
					end
					OP_SCHED: begin
						if (rmatch) begin
							hit_q <= 1'b1;
						end else if (rfree && !free_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q   <= idx_q[IW-1:0];
						end
					end
					OP_QUERY: begin
						if (rmatch) begin
							hit_q  <= 1'b1;
							flag_q <= 1'b1;
							rem_q  <= rrem;
						end
					end
					OP_COLLECT: begin
						if (expired) begin
							rv_q[ridx] <= 1'b0;
							if (rpt_q < RPT_W'(MAX_RESULTS)) begin
								pend_q <= 1'b1;
								rpt_q  <= rpt_q + 1'b1;
							end
						end
					end
					OP_LEFT: begin
						if (rmatch) begin
							rv_q[ridx] <= 1'b0;
							flag_q     <= 1'b1;
						end
						if (jhit) begin
							jv_q[jidx] <= 1'b0;
						end
					end
					default: hit_q <= 1'b1;
				endcase
			end
			if (cmd.finish) begin
				pend_q <= 1'b0;
				if (join_new) begin
					jv_q[jtgt] <= 1'b1;
				end
				if (sched_new) begin
					rv_q[rtgt] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q   <= req_op;
			addr_q <= req_addr;
			now_q  <= req_now;
			dl_q   <= req_dl;
		end
		if (cmd.step) begin
			if (op_q == OP_JOIN && jhit && !jdup) begin
				jt_q[jidx] <= now_q;
			end
			if (op_q == OP_SCHED && rmatch) begin
				rd_q[ridx] <= dl_q;
			end
			if (expired && rpt_q < RPT_W'(MAX_RESULTS)) begin
				pend_addr_q <= ra_q[ridx];
				if (pend_q) begin
					oflag_q <= 1'b1;
					orem_q  <= '0;
					oaddr_q <= pend_addr_q;
					olast_q <= 1'b0;
				end
			end
		end
		if (cmd.finish) begin
			olast_q <= 1'b1;
			orem_q  <= rem_q;
			oaddr_q <= pend_q ? pend_addr_q : 16'h0000;
			case (op_q)
				OP_JOIN: oflag_q <= bad_q || (hit_q && flag_q);
				OP_SCHED: oflag_q <= !bad_q && (hit_q || free_found_q);
				OP_QUERY: oflag_q <= flag_q;
				OP_COLLECT: oflag_q <= pend_q;
				OP_LEFT: oflag_q <= flag_q;
				default: oflag_q <= 1'b0;
			endcase
			if (join_new) begin
				ja_q[jtgt] <= addr_q;
				jt_q[jtgt] <= now_q;
			end
			if (sched_new) begin
				ra_q[rtgt] <= addr_q;
				rd_q[rtgt] <= dl_q;
			end
		end
	end

endmodule

// File: sv/join_dedup_removal_deadline_table.sv
// ----------------------------------------------------------------------------
// join_dedup_removal_deadline_table
// Join de-duplication table and removal deadline table keyed by short address.
//
// Channel  Dir  Word
// req      in   op, dev_addr, now_ms, due_ms
// rsp      out  flag, time_left_ms, expired_addr, last
// cfg      in   dedup_window_ms
//
// One table entry is examined per cycle but for the stall below; at most N
// entries are scanned, N being JOIN_SLOTS, REMOVE_SLOTS or the larger for
// device_left. A rejected address (not collect) or unused code skips the scan.
// A waiting response word stalls collection and completion, not acceptance.
// Reset empties both tables and restores the window to 5000 ms.
// ----------------------------------------------------------------------------
module join_dedup_removal_deadline_table import jdr_pkg::*; #(
	parameter int JOIN_SLOTS   = 8,
	parameter int REMOVE_SLOTS = 8
) (
	input  logic     clk,
	input  logic     arst_n,
	jdr_req_if.sink  req,
	jdr_rsp_if.source rsp,
	jdr_cfg_if.sink  cfg
);

	jdr_cmd_t    cmd;
	jdr_status_t st;

	assign cfg.ready = 1'b1;

	jdr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.st        (st),
		.cmd       (cmd)
	);

	jdr_dp #(
		.JOIN_SLOTS   (JOIN_SLOTS),
		.REMOVE_SLOTS (REMOVE_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.req_op    (req.op),
		.req_addr  (req.dev_addr),
		.req_now   (req.now_ms),
		.req_dl    (req.due_ms),
		.cfg_we    (cfg.valid),
		.cfg_data  (cfg.data),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.rsp_flag  (rsp.flag),
		.rsp_rem   (rsp.time_left_ms),
		.rsp_addr  (rsp.expired_addr),
		.rsp_last  (rsp.last)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while an operation was in flight");

	a_rem_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.time_left_ms != 32'd0) |-> rsp.flag)
		else $error("time left reported without a matching entry");

	a_expired_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.expired_addr != 16'd0) |-> rsp.flag && (rsp.time_left_ms == 32'd0))
		else $error("expired address reported without its flag");

endmodule
